### hw/rtl/reversible_deque_defines.svh
// assertion macros for the reversible deque
// expects clk_i and rst_ni in the scope where the macros are used
`ifndef REVERSIBLE_DEQUE_DEFINES_SVH
`define REVERSIBLE_DEQUE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define RD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deque check failed in same cycle");

// antecedent implies consequent in the next cycle
`define RD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deque check failed in next cycle");

`endif

### hw/rtl/rd_pkg.sv
// shared types and codes for the reversible deque
// used by rd_ctrl, rd_dpath and reversible_deque; depends on nothing
package rd_pkg;

  localparam int DataW = 32;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]              command;
    logic signed [DataW-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] pop_value;
    logic [1:0]              status;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2,
    OP_FLIP = 2'd3
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   at_back;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic reversed;
  } dp_stat_t;

endpackage

### hw/rtl/rd_ctrl.sv
// controller for the reversible deque: decodes commands, issues datapath ops,
// sequences the result cycle; depends on rd_pkg
module rd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        command_i,
  input  rd_pkg::dp_stat_t  dp_stat_i,
  output rd_pkg::dp_cmd_t   dp_cmd_o,
  output logic              res_valid_o,
  output logic [1:0]        res_status_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] status_q, status_d;
  logic       accept, is_push, is_pop, side_back;

  assign accept  = start && (state_q == S_IDLE);
  assign is_push = (command_i == rd_pkg::CMD_PUSH_FRONT) ||
                   (command_i == rd_pkg::CMD_PUSH_BACK);
  assign is_pop  = (command_i == rd_pkg::CMD_POP_FRONT) ||
                   (command_i == rd_pkg::CMD_POP_BACK);
  // requested side, swapped while reversed
  assign side_back = ((command_i == rd_pkg::CMD_PUSH_BACK) ||
                      (command_i == rd_pkg::CMD_POP_BACK)) ^ dp_stat_i.reversed;

  always_comb begin
    state_d          = state_q;
    status_d         = status_q;
    dp_cmd_o.op      = rd_pkg::OP_NONE;
    dp_cmd_o.at_back = side_back;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (is_push) begin
            if (dp_stat_i.full) begin
              status_d = rd_pkg::STAT_FULL;
              state_d  = S_RESP;
            end else begin
              dp_cmd_o.op = rd_pkg::OP_PUSH;
            end
          end else if (is_pop) begin
            state_d = S_RESP;
            if (dp_stat_i.empty) begin
              status_d = rd_pkg::STAT_EMPTY;
            end else begin
              status_d    = rd_pkg::STAT_OK;
              dp_cmd_o.op = rd_pkg::OP_POP;
            end
          end else begin
            // any other code toggles direction
            dp_cmd_o.op = rd_pkg::OP_FLIP;
          end
        end
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= rd_pkg::STAT_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  assign busy         = (state_q != S_IDLE);
  assign res_valid_o  = (state_q == S_RESP);
  assign res_status_o = status_q;

endmodule

### hw/rtl/rd_dpath.sv
// datapath for the reversible deque: ring buffer memory, head and count
// pointers, direction flag; depends on rd_pkg
module rd_dpath #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rd_pkg::dp_cmd_t          dp_cmd_i,
  input  logic [rd_pkg::DataW-1:0] wdata_i,
  output rd_pkg::dp_stat_t         dp_stat_o,
  output logic [rd_pkg::DataW-1:0] rdata_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);
  localparam logic [SW-1:0] DepthS   = SW'(DEPTH);
  localparam logic [CW-1:0] DepthC   = CW'(DEPTH);

  logic [rd_pkg::DataW-1:0] mem_q [DEPTH];
  logic [rd_pkg::DataW-1:0] rdata_q;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          rev_q, rev_d;

  logic [CW-1:0] offset;
  logic [SW-1:0] sum, sum_wrap;
  logic [AW-1:0] back_slot, head_inc, head_dec, slot;
  logic          is_push, is_pop;

  assign is_push = (dp_cmd_i.op == rd_pkg::OP_PUSH);
  assign is_pop  = (dp_cmd_i.op == rd_pkg::OP_POP);

  // push at back lands at head+count, pop at back takes head+count-1
  assign offset    = is_push ? count_q : (count_q - CW'(1));
  assign sum       = SW'(head_q) + SW'(offset);
  assign sum_wrap  = sum - DepthS;
  assign back_slot = (sum >= DepthS) ? sum_wrap[AW-1:0] : sum[AW-1:0];
  assign head_inc  = (head_q == LastSlot) ? '0 : (head_q + AW'(1));
  assign head_dec  = (head_q == '0) ? LastSlot : (head_q - AW'(1));
  assign slot      = dp_cmd_i.at_back ? back_slot : (is_push ? head_dec : head_q);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    rev_d   = rev_q;
    unique case (dp_cmd_i.op)
      rd_pkg::OP_PUSH: begin
        count_d = count_q + CW'(1);
        if (!dp_cmd_i.at_back) begin
          head_d = head_dec;
        end
      end
      rd_pkg::OP_POP: begin
        count_d = count_q - CW'(1);
        if (!dp_cmd_i.at_back) begin
          head_d = head_inc;
        end
      end
      rd_pkg::OP_FLIP: begin
        rev_d = !rev_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      rev_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      rev_q   <= rev_d;
    end
  end

  // single port ring buffer, registered read
  always_ff @(posedge clk_i) begin
    if (is_push) begin
      mem_q[slot] <= wdata_i;
    end
    if (is_pop) begin
      rdata_q <= mem_q[slot];
    end
  end

  assign dp_stat_o.empty    = (count_q == '0);
  assign dp_stat_o.full     = (count_q == DepthC);
  assign dp_stat_o.reversed = rev_q;
  assign rdata_o            = rdata_q;

endmodule

### hw/rtl/reversible_deque.sv
// top level of the reversible deque: a double-ended queue in a ring buffer
// with a direction flag. Depends on rd_pkg, rd_ctrl, rd_dpath and the defines
//
// Usage:
//   Drive item_i and raise start. The item is taken at a rising edge where
//   start is high and busy is low. Commands: push front, push back, pop
//   front, pop back, anything else toggles the direction (front and back
//   swap roles while the flag is set).
//   A successful push or a direction toggle gives no result and leaves
//   busy low; a new item can follow in the next cycle.
//   A pop, or a push into a full queue, gives one result: result_valid_o is
//   high for exactly one cycle, which starts at the accepting edge, with result_o
//   holding the popped value or zero plus a status code. busy is high in
//   that cycle, so the next item waits for the result; for a pop, that
//   cycle also covers the registered read of the single-port entry memory.
//   The receiver cannot stall; each result is on the ports for one cycle.
//   Reset (rst_ni low, asynchronous) empties the queue, clears the direction
//   flag and drops any pending result. The entry memory is not cleared; only
//   written slots are ever read.
`include "reversible_deque_defines.svh"

module reversible_deque #(
  parameter int DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rd_pkg::in_item_t  item_i,
  output logic              result_valid_o,
  output rd_pkg::out_item_t result_o
);

  rd_pkg::dp_cmd_t          dp_cmd;
  rd_pkg::dp_stat_t         dp_stat;
  logic [rd_pkg::DataW-1:0] rdata;
  logic [1:0]               res_status;

  rd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (item_i.command),
    .dp_stat_i    (dp_stat),
    .dp_cmd_o     (dp_cmd),
    .res_valid_o  (result_valid_o),
    .res_status_o (res_status)
  );

  rd_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .dp_cmd_i  (dp_cmd),
    .wdata_i   (item_i.push_value),
    .dp_stat_o (dp_stat),
    .rdata_o   (rdata)
  );

  assign result_o.status    = res_status;
  assign result_o.pop_value = (res_status == rd_pkg::STAT_OK) ? rdata : '0;

  `RD_ASSERT_NEXT(a_one_result, result_valid_o, !result_valid_o)
  `RD_ASSERT_NEXT(a_pop_gives_result,
    start && !busy && (item_i.command == rd_pkg::CMD_POP_FRONT ||
    item_i.command == rd_pkg::CMD_POP_BACK), result_valid_o)
  `RD_ASSERT_NEXT(a_push_silent,
    start && !busy && !dp_stat.full && (item_i.command == rd_pkg::CMD_PUSH_FRONT ||
    item_i.command == rd_pkg::CMD_PUSH_BACK), !result_valid_o)
  `RD_ASSERT_SAME(a_full_not_empty, dp_stat.full, !dp_stat.empty)

endmodule

### bench/tb_reversible_deque.sv
// self-checking bench for reversible_deque: random and directed deque commands
// checked against a shadow deque held in a scoreboard class
// depends on rd_pkg and the reversible_deque rtl
module tb_reversible_deque;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 1024;
  localparam int StallLimit = 1000;

  // command codes with no name in the package: all of them toggle direction
  localparam logic [2:0] CMD_FLIP   = 3'd4;
  localparam logic [2:0] CMD_RSVD_5 = 3'd5;
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;

  class deque_scoreboard;
    int                              slots;
    logic signed [rd_pkg::DataW-1:0] ring[];
    int                              head;
    int                              fill;
    bit                              flipped;
    rd_pkg::out_item_t               owed_results[$];
    int                              errors;

    function new(int n);
      slots = n;
      ring = new[n];
      head = 0;
      fill = 0;
      flipped = 1'b0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function int pending();
      return owed_results.size();
    endfunction

    // apply one accepted item to the shadow deque, queue its result if it has one
    task note_item(rd_pkg::in_item_t it);
      logic              back_side;
      int                slot;
      rd_pkg::out_item_t want;
      want = '0;
      if (it.command > rd_pkg::CMD_POP_BACK) begin
        flipped = !flipped;
        return;
      end
      back_side = it.command[0] ^ flipped;
      if (it.command == rd_pkg::CMD_PUSH_FRONT || it.command == rd_pkg::CMD_PUSH_BACK) begin
        if (fill == slots) begin
          want.status = rd_pkg::STAT_FULL;
          owed_results = {owed_results, want};
          return;
        end
        if (back_side) begin
          slot = (head + fill) % slots;
        end else begin
          head = (head + slots - 1) % slots;
          slot = head;
        end
        ring[slot] = it.push_value;
        fill++;
        return;
      end
      if (fill == 0) begin
        want.status = rd_pkg::STAT_EMPTY;
        owed_results = {owed_results, want};
        return;
      end
      if (back_side) begin
        slot = (head + fill - 1) % slots;
      end else begin
        slot = head;
        head = (head + 1) % slots;
      end
      fill--;
      want.pop_value = ring[slot];
      want.status = rd_pkg::STAT_OK;
      owed_results = {owed_results, want};
    endtask

    task check_result(rd_pkg::out_item_t got);
      rd_pkg::out_item_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("unexpected result value %0d status %0d", got.pop_value, got.status));
        return;
      end
      want = owed_results[0];
      owed_results.delete(0);
      if (got.pop_value !== want.pop_value)
        report($sformatf("pop_value %0d, wanted %0d", got.pop_value, want.pop_value));
      if (got.status !== want.status)
        report($sformatf("status %0d, wanted %0d", got.status, want.status));
    endtask

    task flush();
      while (owed_results.size() != 0) begin
        owed_results.delete(0);
        report("result never arrived");
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  rd_pkg::in_item_t  item_i = '0;
  logic              result_valid_o;
  rd_pkg::out_item_t result_o;
  int                stall_cycles = 0;

  deque_scoreboard sb = new(DEPTH);

  reversible_deque #(.DEPTH(DEPTH)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always #5 clk_i = ~clk_i;

  // results are checked before the item taken at the same edge is applied
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ($isunknown(result_valid_o)) sb.report("result strobe unknown");
      else if (result_valid_o) sb.check_result(result_o);
      if (start && $isunknown(busy)) sb.report("busy unknown");
      else if (start && !busy) sb.note_item(item_i);
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o === 1'b1) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [2:0] cmd,
                           input logic signed [rd_pkg::DataW-1:0] val);
    start <= 1'b1;
    item_i <= '{command: cmd, push_value: val};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // lower start and wait until every owed result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic int gap_len(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [rd_pkg::DataW-1:0] rand_value();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      2: return {1'b0, {(rd_pkg::DataW-1){1'b1}}};
      3: return {1'b1, {(rd_pkg::DataW-1){1'b0}}};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] rand_command(input int push_pct, input int pop_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct)
      return $urandom_range(0, 1) ? rd_pkg::CMD_PUSH_BACK : rd_pkg::CMD_PUSH_FRONT;
    if (r < push_pct + pop_pct)
      return $urandom_range(0, 1) ? rd_pkg::CMD_POP_BACK : rd_pkg::CMD_POP_FRONT;
    case ($urandom_range(0, 3))
      0: return CMD_FLIP;
      1: return CMD_RSVD_5;
      2: return CMD_RSVD_6;
      default: return CMD_RSVD_7;
    endcase
  endfunction

  task automatic random_run(input int n, input int push_pct, input int pop_pct);
    bit quiet;
    quiet = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_item(rand_command(push_pct, pop_pct), rand_value());
      hold_off(gap_len(quiet));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty pops, extreme values, both sides, direction toggles incl. unused codes
    send_item(rd_pkg::CMD_POP_FRONT, '0);
    send_item(rd_pkg::CMD_POP_BACK, '0);
    send_item(rd_pkg::CMD_PUSH_FRONT, {1'b0, {(rd_pkg::DataW-1){1'b1}}});
    send_item(rd_pkg::CMD_PUSH_BACK, {1'b1, {(rd_pkg::DataW-1){1'b0}}});
    send_item(rd_pkg::CMD_PUSH_FRONT, '0);
    send_item(rd_pkg::CMD_PUSH_BACK, '1);
    send_item(rd_pkg::CMD_POP_FRONT, '0);
    send_item(rd_pkg::CMD_POP_BACK, '0);
    send_item(CMD_FLIP, '0);
    send_item(rd_pkg::CMD_PUSH_FRONT, 32'h1234_5678);
    send_item(rd_pkg::CMD_PUSH_BACK, 32'h8765_4321);
    send_item(rd_pkg::CMD_POP_FRONT, '0);
    send_item(CMD_RSVD_5, '1);
    send_item(rd_pkg::CMD_POP_BACK, '0);
    send_item(CMD_RSVD_6, '0);
    send_item(rd_pkg::CMD_POP_FRONT, '0);
    send_item(CMD_RSVD_7, '1);
    send_item(rd_pkg::CMD_POP_BACK, '0);
    send_item(rd_pkg::CMD_POP_FRONT, '0);
    send_item(rd_pkg::CMD_POP_BACK, '0);
    hold_off(3);

    // hover near empty, then fill past full, then drain part of it
    random_run(300, 45, 45);
    random_run(1100, 98, 1);
    drain_results();
    random_run(600, 8, 90);

    drain_results();
    repeat (4) @(posedge clk_i);
    sb.flush();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
